// ===== hdl/tcgc_pkg.sv =====
// Shared types and constants for the touch click gesture classifier.
// No dependencies; imported by touch_click_gesture_classifier_unit.
package tcgc_pkg;

    localparam int TIME_W     = 32;
    localparam int COORD_W    = 12;
    localparam int BTN_W      = 8;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 40;
    localparam int PAGE_W     = 3;

    localparam logic [BTN_W-1:0] NONE_BTN = 8'hFF;

    localparam logic [CFG_IDX_W-1:0] CFG_DBL_WINDOW   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REDRAW_DELAY = 2'd1;

    localparam logic [1:0] GEST_CLICK = 2'd1;
    localparam logic [1:0] GEST_LONG  = 2'd2;
    localparam logic [1:0] EV_RELEASE = 2'd1;
    localparam logic [1:0] EV_CONTACT = 2'd2;

    typedef enum logic [2:0] {
        KIND_SINGLE     = 3'd0,
        KIND_DOUBLE     = 3'd1,
        KIND_LATCH      = 3'd2,
        KIND_LONG_START = 3'd3,
        KIND_LONG_END   = 3'd4,
        KIND_REDRAW     = 3'd5
    } kind_t;

    typedef struct packed {
        logic [TIME_W-1:0]  time_now;
        logic               touch_present;
        logic [1:0]         gesture;
        logic [2:0]         points;
        logic [1:0]         touch_event;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [BTN_W-1:0]   button;
        logic [PAGE_W-1:0]  page;
    } item_t;

    typedef struct packed {
        kind_t              kind;
        logic [BTN_W-1:0]   which_button;
        logic [COORD_W-1:0] out_x;
        logic [COORD_W-1:0] out_y;
        logic               latched;
        logic               last;
    } result_t;

endpackage

// ===== hdl/touch_click_gesture_classifier_unit.sv =====
// Touch click gesture classifier: top level, input register, classifier and result queue.
// Depends on tcgc_pkg.

// Each input beat (a time tick or a touch report) is held in the input register until
// it can go, is classified there against the stored click, long-press and redraw
// state, and its zero to three results are written into a four-entry result queue that
// drains one beat per cycle while m_axis_tready is high. A new beat is taken every cycle
// as long as the queue holds at most one result when the held beat is classified; else
// the held beat waits in the input register. Configuration writes are taken every cycle.
module touch_click_gesture_classifier_unit
    import tcgc_pkg::*;
#(
    parameter int PAGES = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // time_now[31:0], gesture[33:32], points[36:34], touch_event[38:37],
    // x[50:39], y[62:51], button[70:63], page[73:71], zero fill above
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // touch_present
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // which_button[7:0], out_x[19:8], out_y[31:20], latched[32], zero fill above
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // kind
    output logic [2:0]            m_axis_tuser,
    output logic                  m_axis_tlast,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data
);

    localparam int PIDX_W = (PAGES > 1) ? $clog2(PAGES) : 1;

    // configuration
    logic [CFG_W-1:0] window_reg;
    logic [CFG_W-1:0] delay_reg;

    // input register
    logic  in_vld_reg;
    item_t in_reg;
    logic  go;

    // classifier state
    logic [TIME_W-1:0]  first_time_reg,   first_time_next;
    logic [BTN_W-1:0]   first_btn_reg,    first_btn_next;
    logic               awaiting_reg,     awaiting_next;
    logic [BTN_W-1:0]   owner_reg,        owner_next;
    logic [TIME_W-1:0]  redraw_start_reg, redraw_start_next;
    logic               redraw_pend_reg,  redraw_pend_next;
    logic [BTN_W-1:0]   redraw_tgt_reg,   redraw_tgt_next;
    logic [COORD_W-1:0] stored_x_reg;
    logic [COORD_W-1:0] stored_y_reg;
    logic [PAGES-1:0]   page_latch_reg;

    // result queue
    result_t    queue_reg [4];
    logic [1:0] wr_ptr_reg;
    logic [1:0] rd_ptr_reg;
    logic [2:0] cnt_reg;
    logic       pop;

    // classification
    logic [TIME_W-1:0] click_age;
    logic [TIME_W-1:0] redraw_age;
    logic              late_click;
    logic              fire_redraw;
    logic              click;
    logic              dbl;
    logic              latch_hit;
    logic              lp_contact;
    logic              lp_release;
    logic              lp_start;
    logic              lp_end;
    logic [6:0]        page_mod;
    logic [PIDX_W-1:0] page_idx;
    logic              new_latch;
    result_t           cand [3];
    logic [2:0]        cand_vld;
    logic [1:0]        off1;
    logic [1:0]        off2;
    logic [1:0]        n_res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= 16'd300;
            delay_reg  <= 16'd1000;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_DBL_WINDOW:   window_reg <= cfg_data;
                CFG_REDRAW_DELAY: delay_reg  <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Hold the beat until the queue can take all of its results.
    assign go            = in_vld_reg && (cnt_reg <= 3'd1);
    assign s_axis_tready = !in_vld_reg || go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (s_axis_tready)
            in_vld_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_reg.time_now      <= s_axis_tdata[31:0];
            in_reg.touch_present <= s_axis_tuser;
            in_reg.gesture       <= s_axis_tdata[33:32];
            in_reg.points        <= s_axis_tdata[36:34];
            in_reg.touch_event   <= s_axis_tdata[38:37];
            in_reg.x             <= s_axis_tdata[50:39];
            in_reg.y             <= s_axis_tdata[62:51];
            in_reg.button        <= s_axis_tdata[70:63];
            in_reg.page          <= s_axis_tdata[73:71];
        end
    end

    // Fold the page number into the latch range.
    always_comb
    begin
        page_mod = {4'd0, in_reg.page};
        for (int i = 0; i < 7; i++)
        begin
            if (page_mod >= 7'(PAGES))
                page_mod = page_mod - 7'(PAGES);
        end
        page_idx = page_mod[PIDX_W-1:0];
    end

    always_comb
    begin
        click_age   = in_reg.time_now - first_time_reg;
        redraw_age  = in_reg.time_now - redraw_start_reg;
        late_click  = awaiting_reg && (click_age > {16'd0, window_reg});
        // a timed-out click restarts the redraw timer, so it cannot fire too
        fire_redraw = !late_click && redraw_pend_reg && (redraw_age > {16'd0, delay_reg});

        click      = in_reg.touch_present && (in_reg.gesture == GEST_CLICK)
                     && (in_reg.points == 3'd0) && (in_reg.touch_event == EV_RELEASE);
        dbl        = click && awaiting_reg && !late_click;
        latch_hit  = click && (in_reg.button == 8'd0);
        lp_contact = in_reg.touch_present && (in_reg.gesture == GEST_LONG)
                     && (in_reg.points == 3'd1) && (in_reg.touch_event == EV_CONTACT);
        lp_release = in_reg.touch_present && (in_reg.gesture == GEST_LONG)
                     && (in_reg.points == 3'd0) && (in_reg.touch_event == EV_RELEASE);
        lp_start   = lp_contact && (owner_reg == NONE_BTN);
        lp_end     = lp_release && (owner_reg != NONE_BTN);
        new_latch  = !page_latch_reg[page_idx];

        // slot 0: timeout result
        cand[0].kind         = late_click ? KIND_SINGLE : KIND_REDRAW;
        cand[0].which_button = late_click ? first_btn_reg : redraw_tgt_reg;
        cand[0].out_x        = late_click ? stored_x_reg : '0;
        cand[0].out_y        = late_click ? stored_y_reg : '0;
        cand[0].latched      = 1'b0;
        cand[0].last         = 1'b0;

        // slot 1: first touch result
        cand[1].latched = 1'b0;
        cand[1].last    = 1'b0;
        cand[1].out_x   = in_reg.x;
        cand[1].out_y   = in_reg.y;
        if (dbl)
        begin
            cand[1].kind         = KIND_DOUBLE;
            cand[1].which_button = first_btn_reg;
        end
        else if (click)
        begin
            cand[1].kind         = KIND_LATCH;
            cand[1].which_button = 8'd0;
            cand[1].out_x        = '0;
            cand[1].out_y        = '0;
            cand[1].latched      = new_latch;
        end
        else if (lp_start)
        begin
            cand[1].kind         = KIND_LONG_START;
            cand[1].which_button = in_reg.button;
        end
        else
        begin
            cand[1].kind         = KIND_LONG_END;
            cand[1].which_button = owner_reg;
        end

        // slot 2: latch state after a double click
        cand[2].kind         = KIND_LATCH;
        cand[2].which_button = 8'd0;
        cand[2].out_x        = '0;
        cand[2].out_y        = '0;
        cand[2].latched      = new_latch;
        cand[2].last         = 1'b0;

        cand_vld[0] = late_click || fire_redraw;
        cand_vld[1] = dbl || latch_hit || lp_start || lp_end;
        cand_vld[2] = dbl && latch_hit;

        cand[0].last = !(cand_vld[1] || cand_vld[2]);
        cand[1].last = !cand_vld[2];
        cand[2].last = 1'b1;

        off1  = {1'b0, cand_vld[0]};
        off2  = {1'b0, cand_vld[0]} + {1'b0, cand_vld[1]};
        n_res = off2 + {1'b0, cand_vld[2]};
    end

    always_comb
    begin
        awaiting_next     = awaiting_reg;
        first_time_next   = first_time_reg;
        first_btn_next    = first_btn_reg;
        owner_next        = owner_reg;
        redraw_start_next = redraw_start_reg;
        redraw_pend_next  = redraw_pend_reg;
        redraw_tgt_next   = redraw_tgt_reg;

        if (late_click)
        begin
            awaiting_next     = 1'b0;
            redraw_start_next = in_reg.time_now;
            redraw_pend_next  = 1'b1;
            redraw_tgt_next   = first_btn_reg;
        end
        else if (fire_redraw)
        begin
            redraw_pend_next = 1'b0;
        end

        if (click)
        begin
            awaiting_next   = !dbl;
            first_time_next = dbl ? '0 : in_reg.time_now;
            first_btn_next  = dbl ? NONE_BTN : in_reg.button;
        end

        if (lp_contact)
            owner_next = in_reg.button;
        if (lp_release)
            owner_next = NONE_BTN;

        if (lp_end)
        begin
            redraw_start_next = in_reg.time_now;
            redraw_pend_next  = 1'b1;
            redraw_tgt_next   = owner_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_time_reg   <= '0;
            first_btn_reg    <= '0;
            awaiting_reg     <= 1'b0;
            owner_reg        <= NONE_BTN;
            redraw_start_reg <= '0;
            redraw_pend_reg  <= 1'b0;
            redraw_tgt_reg   <= NONE_BTN;
            stored_x_reg     <= '0;
            stored_y_reg     <= '0;
            page_latch_reg   <= '0;
        end
        else if (go)
        begin
            first_time_reg   <= first_time_next;
            first_btn_reg    <= first_btn_next;
            awaiting_reg     <= awaiting_next;
            owner_reg        <= owner_next;
            redraw_start_reg <= redraw_start_next;
            redraw_pend_reg  <= redraw_pend_next;
            redraw_tgt_reg   <= redraw_tgt_next;
            if (in_reg.touch_present)
            begin
                stored_x_reg <= in_reg.x;
                stored_y_reg <= in_reg.y;
            end
            if (latch_hit)
                page_latch_reg[page_idx] <= new_latch;
        end
    end

    // Result queue: pack the valid slots in order behind the write pointer.
    assign m_axis_tvalid = (cnt_reg != 3'd0);
    assign pop           = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            if (cand_vld[0])
                queue_reg[wr_ptr_reg] <= cand[0];
            if (cand_vld[1])
                queue_reg[wr_ptr_reg + off1] <= cand[1];
            if (cand_vld[2])
                queue_reg[wr_ptr_reg + off2] <= cand[2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (go)
                wr_ptr_reg <= wr_ptr_reg + n_res;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            cnt_reg <= cnt_reg + (go ? {1'b0, n_res} : 3'd0) - {2'd0, pop};
        end
    end

    assign m_axis_tdata = {7'd0, queue_reg[rd_ptr_reg].latched,
                           queue_reg[rd_ptr_reg].out_y,
                           queue_reg[rd_ptr_reg].out_x,
                           queue_reg[rd_ptr_reg].which_button};
    assign m_axis_tuser = queue_reg[rd_ptr_reg].kind;
    assign m_axis_tlast = queue_reg[rd_ptr_reg].last;

endmodule
